// File: rtl/itac_pkg.sv
// ----------------------------------------------------------------------------
// itac_pkg
// Shared types, codes and helpers of the infix to three-address code block.
// ----------------------------------------------------------------------------
package itac_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned TempWidth  = 16;
  localparam int unsigned ValueWidth = 16;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharOpen  = 8'h28;
  localparam logic [7:0] CharClose = 8'h29;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoZ   = 8'h7A;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_OPEN = 3'd4
  } op_code_e;

  typedef enum logic [2:0] {
    ERR_NONE            = 3'd0,
    ERR_MISSING_OPERAND = 3'd1,
    ERR_UNMATCHED_CLOSE = 3'd2,
    ERR_UNMATCHED_OPEN  = 3'd3,
    ERR_OVERFLOW        = 3'd4
  } err_code_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expression;
  } in_item_t;

  typedef struct packed {
    logic [ValueWidth-1:0] temp_id;
    logic                  left_is_temp;
    logic [ValueWidth-1:0] left_value;
    logic [1:0]            operator_code;
    logic                  right_is_temp;
    logic [ValueWidth-1:0] right_value;
    logic                  line_valid;
    err_code_e             error_code;
    logic                  last_result;
  } out_item_t;

  // binding strength of a stacked operator code
  function automatic logic [1:0] prec(input logic [2:0] code);
    logic [1:0] p;
    if (code == OP_OPEN) begin
      p = 2'd0;
    end else if (code[1]) begin
      p = 2'd2;
    end else begin
      p = 2'd1;
    end
    return p;
  endfunction

endpackage

// File: rtl/itac_if.sv
// ----------------------------------------------------------------------------
// itac_if
// Valid/ready channels carrying input characters and emitted code lines.
// ----------------------------------------------------------------------------
interface itac_in_if;
  logic               valid;
  logic               ready;
  itac_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface itac_out_if;
  logic                valid;
  logic                ready;
  itac_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/infix_to_three_address_code.sv
// ----------------------------------------------------------------------------
// infix_to_three_address_code
// Shunting-yard translator: operator and operand stacks in synchronous RAM,
// one three-address line per reduction.
//
//   channel  dir  payload                          transfer
//   in_i     in   char_code, end_of_expression     valid & ready
//   out_o    out  code line or error marker        valid & ready
//
// operand, open parenthesis, ignored or discarded character: taken in ST_IDLE
// operator, close parenthesis, end mark: a stack RAM read, then ST_LOOK reduces
// with one RAM read per reduction; an end mark while discarding is taken in ST_IDLE
// any error marker is sent from ST_ERR
// reset clears counts, temp counter (to 1), error flag; RAM contents are kept
// a stalled output holds the reduction loop once one line is pending
// ----------------------------------------------------------------------------
module infix_to_three_address_code #(
  parameter int unsigned STACK_DEPTH = itac_pkg::StackDepth,
  parameter int unsigned TEMP_WIDTH  = itac_pkg::TempWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itac_in_if.sink    in_i,
  itac_out_if.source out_o
);

  localparam int unsigned OpndDepth = STACK_DEPTH + 1;
  localparam int unsigned OprAw     = $clog2(STACK_DEPTH);
  localparam int unsigned OprCw     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned OpndAw    = $clog2(OpndDepth);
  localparam int unsigned OpndCw    = $clog2(OpndDepth + 1);
  localparam int unsigned OpndW     = TEMP_WIDTH + 1;
  localparam int unsigned Vw        = itac_pkg::ValueWidth;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_ERR  = 3'b100
  } state_e;

  typedef enum logic [2:0] {
    KIND_OPERATOR = 3'b001,
    KIND_CLOSE    = 3'b010,
    KIND_END      = 3'b100
  } kind_e;

  state_e                 state_q, state_d;
  kind_e                  kind_q, kind_d;
  logic [OprCw-1:0]       opr_cnt_q, opr_cnt_d;
  logic [OpndCw-1:0]      opnd_cnt_q, opnd_cnt_d;
  logic [TEMP_WIDTH-1:0]  temp_q, temp_d;
  logic                   discard_q, discard_d;
  logic                   end_q, end_d;
  logic [2:0]             code_q, code_d;
  logic                   fwd_q, fwd_d;
  logic [TEMP_WIDTH-1:0]  fwd_val_q, fwd_val_d;
  itac_pkg::err_code_e    err_q, err_d;
  logic                   pend_valid_q, pend_valid_d;
  itac_pkg::out_item_t    pend_q, pend_d;
  logic                   out_valid_q, out_valid_d;
  itac_pkg::out_item_t    out_q, out_d;

  logic [2:0]             opr_mem [STACK_DEPTH];
  logic [OpndW-1:0]       opnd_mem [OpndDepth];
  logic [2:0]             opr_rd_q;
  logic [OpndW-1:0]       left_rd_q;
  logic [OpndW-1:0]       right_rd_q;

  logic                   rd_en;
  logic [OprAw-1:0]       opr_raddr;
  logic [OpndAw-1:0]      left_raddr;
  logic [OpndAw-1:0]      right_raddr;
  logic                   opr_we;
  logic [OprAw-1:0]       opr_waddr;
  logic [2:0]             opr_wdata;
  logic                   opnd_we;
  logic [OpndAw-1:0]      opnd_waddr;
  logic [OpndW-1:0]       opnd_wdata;

  logic [7:0]             ch;
  logic                   is_operand, is_open, is_close, is_op;
  logic [2:0]             op_code;
  logic                   out_free;
  logic [OpndW-1:0]       right_opnd;
  logic                   has_op, want_reduce, stop_push, stop_pop;
  itac_pkg::err_code_e    stop_err;
  itac_pkg::out_item_t    line;
  itac_pkg::out_item_t    marker;
  logic [TEMP_WIDTH-1:0]  temp_inc;

  assign ch         = in_i.data.char_code;
  assign is_operand = (ch >= itac_pkg::CharZero && ch <= itac_pkg::CharNine) ||
                      (ch >= itac_pkg::CharUpA && ch <= itac_pkg::CharUpZ) ||
                      (ch >= itac_pkg::CharLoA && ch <= itac_pkg::CharLoZ);
  assign is_open    = ch == itac_pkg::CharOpen;
  assign is_close   = ch == itac_pkg::CharClose;

  always_comb begin
    is_op   = 1'b1;
    op_code = itac_pkg::OP_ADD;
    unique case (ch)
      itac_pkg::CharPlus:  op_code = itac_pkg::OP_ADD;
      itac_pkg::CharMinus: op_code = itac_pkg::OP_SUB;
      itac_pkg::CharStar:  op_code = itac_pkg::OP_MUL;
      itac_pkg::CharSlash: op_code = itac_pkg::OP_DIV;
      default:             is_op = 1'b0;
    endcase
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign right_opnd = fwd_q ? {1'b1, fwd_val_q} : right_rd_q;
  assign has_op     = opr_cnt_q != '0;
  assign temp_inc   = (temp_q == '1) ? TEMP_WIDTH'(1) : temp_q + TEMP_WIDTH'(1);

  // stop decision of the reduction loop
  always_comb begin
    want_reduce = 1'b0;
    stop_push   = 1'b0;
    stop_pop    = 1'b0;
    stop_err    = itac_pkg::ERR_NONE;
    unique case (kind_q)
      KIND_OPERATOR: begin
        want_reduce = has_op && (itac_pkg::prec(opr_rd_q) >= itac_pkg::prec(code_q));
        if (opr_cnt_q == OprCw'(STACK_DEPTH)) begin
          stop_err = itac_pkg::ERR_OVERFLOW;
        end else begin
          stop_push = 1'b1;
        end
      end
      KIND_CLOSE: begin
        want_reduce = has_op && (opr_rd_q != itac_pkg::OP_OPEN);
        if (has_op) begin
          stop_pop = 1'b1;
        end else begin
          stop_err = itac_pkg::ERR_UNMATCHED_CLOSE;
        end
      end
      KIND_END: begin
        want_reduce = has_op && (opr_rd_q != itac_pkg::OP_OPEN);
        if (has_op) begin
          stop_err = itac_pkg::ERR_UNMATCHED_OPEN;
        end
      end
      default: begin
        want_reduce = 1'b0;
      end
    endcase
    if (want_reduce && opnd_cnt_q < OpndCw'(2)) begin
      want_reduce = 1'b0;
      stop_push   = 1'b0;
      stop_pop    = 1'b0;
      stop_err    = itac_pkg::ERR_MISSING_OPERAND;
    end
  end

  always_comb begin
    line               = '0;
    line.temp_id       = Vw'(temp_q);
    line.left_is_temp  = left_rd_q[OpndW-1];
    line.left_value    = Vw'(left_rd_q[TEMP_WIDTH-1:0]);
    line.operator_code = opr_rd_q[1:0];
    line.right_is_temp = right_opnd[OpndW-1];
    line.right_value   = Vw'(right_opnd[TEMP_WIDTH-1:0]);
    line.line_valid    = 1'b1;
    line.error_code    = itac_pkg::ERR_NONE;
    line.last_result   = 1'b0;
    marker             = '0;
    marker.error_code  = err_q;
    marker.last_result = 1'b1;
  end

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    opr_cnt_d    = opr_cnt_q;
    opnd_cnt_d   = opnd_cnt_q;
    temp_d       = temp_q;
    discard_d    = discard_q;
    end_d        = end_q;
    code_d       = code_q;
    fwd_d        = fwd_q;
    fwd_val_d    = fwd_val_q;
    err_d        = err_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_d        = out_q;
    rd_en        = 1'b0;
    opr_raddr    = OprAw'(opr_cnt_q - OprCw'(1));
    left_raddr   = OpndAw'(opnd_cnt_q - OpndCw'(2));
    right_raddr  = OpndAw'(opnd_cnt_q - OpndCw'(1));
    opr_we       = 1'b0;
    opr_waddr    = opr_cnt_q[OprAw-1:0];
    opr_wdata    = code_q;
    opnd_we      = 1'b0;
    opnd_waddr   = opnd_cnt_q[OpndAw-1:0];
    opnd_wdata   = {1'b0, TEMP_WIDTH'(ch)};

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          end_d = in_i.data.end_of_expression;
          fwd_d = 1'b0;
          if (in_i.data.end_of_expression) begin
            if (discard_q) begin
              opr_cnt_d  = '0;
              opnd_cnt_d = '0;
              discard_d  = 1'b0;
            end else begin
              kind_d  = KIND_END;
              rd_en   = 1'b1;
              state_d = ST_LOOK;
            end
          end else if (!discard_q) begin
            if (is_operand) begin
              if (opnd_cnt_q == OpndCw'(OpndDepth)) begin
                err_d   = itac_pkg::ERR_OVERFLOW;
                state_d = ST_ERR;
              end else begin
                opnd_we    = 1'b1;
                opnd_cnt_d = opnd_cnt_q + OpndCw'(1);
              end
            end else if (is_open) begin
              if (opr_cnt_q == OprCw'(STACK_DEPTH)) begin
                err_d   = itac_pkg::ERR_OVERFLOW;
                state_d = ST_ERR;
              end else begin
                opr_we    = 1'b1;
                opr_wdata = itac_pkg::OP_OPEN;
                opr_cnt_d = opr_cnt_q + OprCw'(1);
              end
            end else if (is_close) begin
              kind_d  = KIND_CLOSE;
              rd_en   = 1'b1;
              state_d = ST_LOOK;
            end else if (is_op) begin
              kind_d  = KIND_OPERATOR;
              code_d  = op_code;
              rd_en   = 1'b1;
              state_d = ST_LOOK;
            end
          end
        end
      end

      ST_LOOK: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d       = 1'b1;
            out_d             = pend_q;
            out_d.last_result = !want_reduce && (stop_err == itac_pkg::ERR_NONE);
          end
          if (want_reduce) begin
            pend_valid_d = 1'b1;
            pend_d       = line;
            temp_d       = temp_inc;
            fwd_d        = 1'b1;
            fwd_val_d    = temp_q;
            opnd_we      = 1'b1;
            opnd_waddr   = OpndAw'(opnd_cnt_q - OpndCw'(2));
            opnd_wdata   = {1'b1, temp_q};
            opnd_cnt_d   = opnd_cnt_q - OpndCw'(1);
            opr_cnt_d    = opr_cnt_q - OprCw'(1);
            rd_en        = 1'b1;
            opr_raddr    = OprAw'(opr_cnt_q - OprCw'(2));
            left_raddr   = OpndAw'(opnd_cnt_q - OpndCw'(3));
          end else begin
            pend_valid_d = 1'b0;
            if (stop_err != itac_pkg::ERR_NONE) begin
              err_d   = stop_err;
              state_d = ST_ERR;
            end else begin
              state_d = ST_IDLE;
              unique case (kind_q)
                KIND_OPERATOR: begin
                  opr_we    = stop_push;
                  opr_cnt_d = opr_cnt_q + OprCw'(1);
                end
                KIND_CLOSE: begin
                  opr_cnt_d = opr_cnt_q - OprCw'(stop_pop);
                end
                KIND_END: begin
                  opr_cnt_d  = '0;
                  opnd_cnt_d = '0;
                  discard_d  = 1'b0;
                end
                default: begin
                  state_d = ST_IDLE;
                end
              endcase
            end
          end
        end
      end

      ST_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = marker;
          state_d     = ST_IDLE;
          if (end_q) begin
            opr_cnt_d  = '0;
            opnd_cnt_d = '0;
            discard_d  = 1'b0;
          end else begin
            discard_d = 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= KIND_END;
      opr_cnt_q    <= '0;
      opnd_cnt_q   <= '0;
      temp_q       <= TEMP_WIDTH'(1);
      discard_q    <= 1'b0;
      end_q        <= 1'b0;
      fwd_q        <= 1'b0;
      err_q        <= itac_pkg::ERR_NONE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      opr_cnt_q    <= opr_cnt_d;
      opnd_cnt_q   <= opnd_cnt_d;
      temp_q       <= temp_d;
      discard_q    <= discard_d;
      end_q        <= end_d;
      fwd_q        <= fwd_d;
      err_q        <= err_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    fwd_val_q <= fwd_val_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  // stack rams
  always_ff @(posedge clk_i) begin
    if (opr_we) begin
      opr_mem[opr_waddr] <= opr_wdata;
    end
    if (opnd_we) begin
      opnd_mem[opnd_waddr] <= opnd_wdata;
    end
    if (rd_en) begin
      opr_rd_q   <= opr_mem[opr_raddr];
      left_rd_q  <= opnd_mem[left_raddr];
      right_rd_q <= opnd_mem[right_raddr];
    end
  end

  assign in_i.ready  = state_q == ST_IDLE;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// File: rtl/itac_checker.sv
// ----------------------------------------------------------------------------
// itac_checker
// Port-level checks of the infix to three-address code block.
// ----------------------------------------------------------------------------
module itac_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input itac_pkg::out_item_t out_data_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output changed while stalled");

  // error marker closes its item and carries no line
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.line_valid |->
      out_data_i.last_result && out_data_i.error_code != itac_pkg::ERR_NONE &&
      out_data_i.temp_id == '0 && out_data_i.left_value == '0 &&
      out_data_i.right_value == '0)
    else $error("malformed error marker");

  // code lines are error free and never define temporary zero
  a_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.line_valid |->
      out_data_i.error_code == itac_pkg::ERR_NONE && out_data_i.temp_id != '0)
    else $error("malformed code line");

endmodule

bind infix_to_three_address_code itac_checker u_itac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
